// File: sv/pab_pkg.sv
// Shared types and constants for the pixel alpha blend writer.
package pab_pkg;

  localparam int COORD_W      = 10;
  localparam int ADDR_W       = 20;
  localparam int PIX_W        = 32;
  localparam int CH_W         = 8;
  localparam int PCT_W        = 7;
  localparam int MAX_SIDE_DEF = 1024;

  localparam int PCT_FULL     = 100;
  localparam int ALPHA_FULL   = 255;

  localparam int DIV3_MUL     = 683;
  localparam int DIV3_SHIFT   = 11;
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV255_MUL   = 32897;
  localparam int DIV255_SHIFT = 23;

  localparam int Q_DEPTH      = 4;
  localparam int QP_W         = $clog2(Q_DEPTH);

  localparam int CFG_DW       = 32;
  localparam int CFG_AW       = 5;
  localparam int REG_IDX_W    = 3;

  localparam logic [COORD_W-1:0] RST_WIDTH  = 10'd240;
  localparam logic [COORD_W-1:0] RST_HEIGHT = 10'd320;

  typedef enum logic [1:0] {
    OUTC_OPAQUE = 2'd0,
    OUTC_BLEND  = 2'd1,
    OUTC_SKIP   = 2'd2,
    OUTC_RANGE  = 2'd3
  } outcome_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_LANDSCAPE = 3'd2,
    REG_MIRROR    = 3'd3,
    REG_DRAWBUF   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic               landscape;
    logic               mirrored;
    logic               draw_buf;
  } cfg_t;

  typedef struct packed {
    outcome_t            outcome;
    logic [ADDR_W-1:0]   addr;
    logic                buf_idx;
    logic [CH_W-1:0]     alpha;
    logic [PIX_W-1:0]    color;
    logic [3*CH_W-1:0]   old_rgb;
  } q_entry_t;

endpackage

// File: sv/pab_if.sv
// Handshake channel interfaces for pixel plots and pixel writes.
interface pab_in_if;
  import pab_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [PIX_W-1:0]   src_color;
  logic               gray_enable;
  logic [PCT_W-1:0]   opacity_pct;
  logic [PIX_W-1:0]   old_pixel;

  modport source (output valid, pos_x, pos_y, src_color, gray_enable, opacity_pct, old_pixel,
                  input ready);
  modport sink (input valid, pos_x, pos_y, src_color, gray_enable, opacity_pct, old_pixel,
                output ready);
endinterface

interface pab_out_if;
  import pab_pkg::*;
  logic              valid;
  logic              ready;
  logic              write_enable;
  logic [ADDR_W-1:0] word_address;
  logic              buffer_index;
  logic [PIX_W-1:0]  new_pixel;
  logic [1:0]        outcome;

  modport source (output valid, write_enable, word_address, buffer_index, new_pixel, outcome,
                  input ready);
  modport sink (input valid, write_enable, word_address, buffer_index, new_pixel, outcome,
                output ready);
endinterface

// File: sv/pab_front.sv
// Front end: accept plots, bounds check, grey and alpha scaling, address, classify.
module pab_front #(
  parameter int MAX_SIDE = pab_pkg::MAX_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pab_pkg::cfg_t     cfg,
  pab_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push,
  output pab_pkg::q_entry_t push_data
);
  import pab_pkg::*;

  localparam int SIDE_MAX = MAX_SIDE - 1;

  logic [COORD_W-1:0] w_cl, h_cl, mx, my, mul_a, mul_b, addend;
  logic [PCT_W-1:0]   sat_pct;
  logic               in_oor;
  logic [COORD_W-1:0] gray_sum;
  logic               adv_f1, adv_f2;

  logic                 f1_v_r, f1_oor_r, f1_gray_r, f1_buf_r;
  logic [PIX_W-1:0]     f1_color_r;
  logic [COORD_W-1:0]   f1_sum_r, f1_mul_a_r, f1_mul_b_r, f1_add_r;
  logic [14:0]          f1_ap_r;
  logic [3*CH_W-1:0]    f1_old_r;

  logic [19:0]          gray_prod;
  logic [27:0]          alpha_prod;
  logic [CH_W-1:0]      gray_m;
  logic [3*CH_W-1:0]    rgb_nxt;
  logic [CH_W-1:0]      alpha_nxt;
  logic [ADDR_W-1:0]    addr_nxt;

  logic                 f2_v_r, f2_oor_r, f2_buf_r;
  logic [CH_W-1:0]      f2_ca_r, f2_alpha_r;
  logic [3*CH_W-1:0]    f2_rgb_r, f2_old_r;
  logic [ADDR_W-1:0]    f2_addr_r;

  always_comb begin
    w_cl = (int'(cfg.width) > SIDE_MAX) ? COORD_W'(SIDE_MAX) : cfg.width;
    h_cl = (int'(cfg.height) > SIDE_MAX) ? COORD_W'(SIDE_MAX) : cfg.height;
    sat_pct = (in_ch.opacity_pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : in_ch.opacity_pct;
    in_oor = (in_ch.pos_x >= w_cl) || (in_ch.pos_y >= h_cl);
    mx = cfg.mirrored ? (w_cl - COORD_W'(1) - in_ch.pos_x) : in_ch.pos_x;
    my = cfg.mirrored ? (h_cl - COORD_W'(1) - in_ch.pos_y) : in_ch.pos_y;
    if (cfg.landscape) begin
      mul_a  = h_cl;
      mul_b  = mx;
      addend = h_cl - COORD_W'(1) - my;
    end else begin
      mul_a  = my;
      mul_b  = w_cl;
      addend = mx;
    end
    gray_sum = COORD_W'(in_ch.src_color[23:16]) + COORD_W'(in_ch.src_color[15:8])
             + COORD_W'(in_ch.src_color[7:0]);
  end

  assign adv_f2      = !f2_v_r || !q_full;
  assign adv_f1      = !f1_v_r || adv_f2;
  assign in_ch.ready = adv_f1;
  assign push        = f2_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (adv_f1) begin
        f1_v_r <= in_ch.valid;
      end
      if (adv_f2) begin
        f2_v_r <= f1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_f1) begin
      f1_oor_r   <= in_oor;
      f1_gray_r  <= in_ch.gray_enable;
      f1_buf_r   <= cfg.draw_buf;
      f1_color_r <= in_ch.src_color;
      f1_sum_r   <= gray_sum;
      f1_ap_r    <= 15'(in_ch.src_color[31:24]) * 15'(sat_pct);
      f1_old_r   <= in_ch.old_pixel[3*CH_W-1:0];
      f1_mul_a_r <= mul_a;
      f1_mul_b_r <= mul_b;
      f1_add_r   <= addend;
    end
  end

  always_comb begin
    gray_prod  = 20'(f1_sum_r) * 20'(DIV3_MUL);
    gray_m     = gray_prod[DIV3_SHIFT +: CH_W];
    rgb_nxt    = f1_gray_r ? {gray_m, gray_m, gray_m} : f1_color_r[3*CH_W-1:0];
    alpha_prod = 28'(f1_ap_r) * 28'(DIV100_MUL);
    alpha_nxt  = alpha_prod[DIV100_SHIFT +: CH_W];
    addr_nxt   = ADDR_W'(f1_mul_a_r) * ADDR_W'(f1_mul_b_r) + ADDR_W'(f1_add_r);
  end

  always_ff @(posedge clk) begin
    if (adv_f2) begin
      f2_oor_r   <= f1_oor_r;
      f2_buf_r   <= f1_buf_r;
      f2_ca_r    <= f1_color_r[PIX_W-1 -: CH_W];
      f2_rgb_r   <= rgb_nxt;
      f2_old_r   <= f1_old_r;
      f2_alpha_r <= alpha_nxt;
      f2_addr_r  <= addr_nxt;
    end
  end

  always_comb begin
    push_data.addr    = f2_addr_r;
    push_data.buf_idx = f2_buf_r;
    push_data.alpha   = f2_alpha_r;
    push_data.color   = {f2_ca_r, f2_rgb_r};
    push_data.old_rgb = f2_old_r;
    if (f2_oor_r) begin
      push_data.outcome = OUTC_RANGE;
    end else if (f2_alpha_r == '0) begin
      push_data.outcome = OUTC_SKIP;
    end else if (f2_alpha_r == CH_W'(ALPHA_FULL)) begin
      push_data.outcome = OUTC_OPAQUE;
    end else begin
      push_data.outcome = OUTC_BLEND;
    end
  end

endmodule

// File: sv/pab_queue.sv
// Short FIFO of classified plots between the front and back ends.
module pab_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pab_pkg::q_entry_t push_data,
  input  logic              pop,
  output pab_pkg::q_entry_t pop_data,
  output logic              full,
  output logic              empty
);
  import pab_pkg::*;

  q_entry_t          mem_r [Q_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QP_W:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QP_W+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QP_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QP_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QP_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/pab_back.sv
// Back end: channel blend products, divide by 255 and output register.
module pab_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  pab_pkg::q_entry_t pop_data,
  output logic              pop,
  pab_out_if.source         out_ch
);
  import pab_pkg::*;

  logic adv_o, adv_b1;

  logic               b1_v_r;
  outcome_t           b1_outcome_r;
  logic [ADDR_W-1:0]  b1_addr_r;
  logic               b1_buf_r;
  logic [PIX_W-1:0]   b1_color_r;
  logic [15:0]        b1_mix_r [3];
  logic [15:0]        mix_nxt [3];

  logic [31:0]        dprod [3];
  logic [3*CH_W-1:0]  blend_rgb;

  logic               o_v_r, o_we_r, o_buf_r;
  logic [ADDR_W-1:0]  o_addr_r;
  logic [PIX_W-1:0]   o_pix_r;
  outcome_t           o_outcome_r;
  logic               we_nxt;
  logic [ADDR_W-1:0]  addr_nxt;
  logic [PIX_W-1:0]   pix_nxt;

  assign adv_o  = !o_v_r || out_ch.ready;
  assign adv_b1 = !b1_v_r || adv_o;
  assign pop    = !empty && adv_b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix_nxt[i] = 16'(pop_data.old_rgb[i*CH_W +: CH_W])
                     * 16'(CH_W'(ALPHA_FULL) - pop_data.alpha)
                 + 16'(pop_data.color[i*CH_W +: CH_W]) * 16'(pop_data.alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (adv_b1) begin
        b1_v_r <= !empty;
      end
      if (adv_o) begin
        o_v_r <= b1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b1) begin
      b1_outcome_r <= pop_data.outcome;
      b1_addr_r    <= pop_data.addr;
      b1_buf_r     <= pop_data.buf_idx;
      b1_color_r   <= pop_data.color;
      for (int i = 0; i < 3; i++) begin
        b1_mix_r[i] <= mix_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dprod[i] = 32'(b1_mix_r[i]) * 32'(DIV255_MUL);
      blend_rgb[i*CH_W +: CH_W] = dprod[i][DIV255_SHIFT +: CH_W];
    end
    case (b1_outcome_r)
      OUTC_OPAQUE: begin
        we_nxt   = 1'b1;
        addr_nxt = b1_addr_r;
        pix_nxt  = b1_color_r;
      end
      OUTC_BLEND: begin
        we_nxt   = 1'b1;
        addr_nxt = b1_addr_r;
        pix_nxt  = {CH_W'(ALPHA_FULL), blend_rgb};
      end
      OUTC_SKIP: begin
        we_nxt   = 1'b0;
        addr_nxt = b1_addr_r;
        pix_nxt  = '0;
      end
      default: begin
        we_nxt   = 1'b0;
        addr_nxt = '0;
        pix_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      o_we_r      <= we_nxt;
      o_addr_r    <= addr_nxt;
      o_buf_r     <= b1_buf_r;
      o_pix_r     <= pix_nxt;
      o_outcome_r <= b1_outcome_r;
    end
  end

  assign out_ch.valid        = o_v_r;
  assign out_ch.write_enable = o_we_r;
  assign out_ch.word_address = o_addr_r;
  assign out_ch.buffer_index = o_buf_r;
  assign out_ch.new_pixel    = o_pix_r;
  assign out_ch.outcome      = o_outcome_r;

endmodule

// File: sv/pixel_alpha_blend_writer_unit.sv
// Top level of the pixel alpha blend writer: register file and front/queue/back.
// Takes one pixel plot per clock while the result side keeps up and returns one write
// result per plot, in order. Each plot passes two front stages, the queue entry, the
// blend-product stage and the output register. The front and back are parted by a
// four-entry queue, so a stalled result side fills the queue before in_pix.ready drops.
// Registers sit at byte addresses 0, 4, 8, 12, 16 (width, height, landscape, mirror,
// draw buffer) must be written only while idle; the block itself does not enforce this.
module pixel_alpha_blend_writer_unit #(
  parameter int MAX_SIDE = pab_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pab_in_if.sink                       in_pix,
  pab_out_if.source                    out_pix,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pab_pkg::CFG_AW-1:0]   paddr,
  input  logic [pab_pkg::CFG_DW-1:0]   pwdata,
  output logic [pab_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import pab_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 q_full, q_empty, q_push, q_pop;
  q_entry_t             q_push_data, q_pop_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width     <= RST_WIDTH;
      cfg_r.height    <= RST_HEIGHT;
      cfg_r.landscape <= 1'b0;
      cfg_r.mirrored  <= 1'b0;
      cfg_r.draw_buf  <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WIDTH:     cfg_r.width     <= pwdata[COORD_W-1:0];
        REG_HEIGHT:    cfg_r.height    <= pwdata[COORD_W-1:0];
        REG_LANDSCAPE: cfg_r.landscape <= pwdata[0];
        REG_MIRROR:    cfg_r.mirrored  <= pwdata[0];
        REG_DRAWBUF:   cfg_r.draw_buf  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:     prdata = CFG_DW'(cfg_r.width);
      REG_HEIGHT:    prdata = CFG_DW'(cfg_r.height);
      REG_LANDSCAPE: prdata = CFG_DW'(cfg_r.landscape);
      REG_MIRROR:    prdata = CFG_DW'(cfg_r.mirrored);
      REG_DRAWBUF:   prdata = CFG_DW'(cfg_r.draw_buf);
      default:       prdata = '0;
    endcase
  end

  pab_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_pix),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  pab_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  pab_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (q_empty),
    .pop_data (q_pop_data),
    .pop      (q_pop),
    .out_ch   (out_pix)
  );

endmodule

// File: sim/tb_pixel_alpha_blend_writer_unit.sv
// Testbench for the pixel alpha blend writer: random plots checked against a blend predictor.
`timescale 1ns / 100ps

module tb_pixel_alpha_blend_writer_unit;
  import pab_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [PIX_W-1:0]   src_color;
    logic               gray_enable;
    logic [PCT_W-1:0]   opacity_pct;
    logic [PIX_W-1:0]   old_pixel;
  } plot_t;

  typedef struct {
    logic              write_enable;
    logic [ADDR_W-1:0] word_address;
    logic              buffer_index;
    logic [PIX_W-1:0]  new_pixel;
    outcome_t          outcome;
  } pix_write_t;

  class blend_scoreboard;
    cfg_t       cfg;
    pix_write_t expected_writes[$];
    int         mismatches;

    function new();
      cfg.width     = RST_WIDTH;
      cfg.height    = RST_HEIGHT;
      cfg.landscape = 1'b0;
      cfg.mirrored  = 1'b0;
      cfg.draw_buf  = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DW-1:0] v);
      case (idx)
        REG_WIDTH:     cfg.width     = v[COORD_W-1:0];
        REG_HEIGHT:    cfg.height    = v[COORD_W-1:0];
        REG_LANDSCAPE: cfg.landscape = v[0];
        REG_MIRROR:    cfg.mirrored  = v[0];
        REG_DRAWBUF:   cfg.draw_buf  = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned mix_ch(int unsigned o, int unsigned n, int unsigned a);
      return (o * (ALPHA_FULL - a) + n * a) / ALPHA_FULL;
    endfunction

    function pix_write_t blend_pixel(plot_t p);
      pix_write_t  r;
      int unsigned w, h, x, y, pct, a, ca, cr, cg, cb, gray, addr;
      w = (32'(cfg.width) > MAX_SIDE_DEF - 1) ? MAX_SIDE_DEF - 1 : 32'(cfg.width);
      h = (32'(cfg.height) > MAX_SIDE_DEF - 1) ? MAX_SIDE_DEF - 1 : 32'(cfg.height);
      x = 32'(p.pos_x);
      y = 32'(p.pos_y);
      r.buffer_index = cfg.draw_buf;
      r.write_enable = 1'b0;
      r.word_address = '0;
      r.new_pixel    = '0;
      r.outcome      = OUTC_RANGE;
      if (x >= w || y >= h) return r;

      ca = 32'(p.src_color[31:24]);
      cr = 32'(p.src_color[23:16]);
      cg = 32'(p.src_color[15:8]);
      cb = 32'(p.src_color[7:0]);
      if (p.gray_enable) begin
        gray = (cr + cg + cb) / 3;
        cr = gray;
        cg = gray;
        cb = gray;
      end
      pct = (32'(p.opacity_pct) > PCT_FULL) ? PCT_FULL : 32'(p.opacity_pct);
      a = (ca * pct) / PCT_FULL;

      if (cfg.mirrored) begin
        x = w - 1 - x;
        y = h - 1 - y;
      end
      if (cfg.landscape) addr = (h - 1 - y) + h * x;
      else addr = y * w + x;
      r.word_address = addr[ADDR_W-1:0];

      if (a == 0) begin
        r.outcome = OUTC_SKIP;
      end else if (a == ALPHA_FULL) begin
        r.write_enable = 1'b1;
        r.new_pixel    = {ca[7:0], cr[7:0], cg[7:0], cb[7:0]};
        r.outcome      = OUTC_OPAQUE;
      end else begin
        cr = mix_ch(32'(p.old_pixel[23:16]), cr, a);
        cg = mix_ch(32'(p.old_pixel[15:8]), cg, a);
        cb = mix_ch(32'(p.old_pixel[7:0]), cb, a);
        r.write_enable = 1'b1;
        r.new_pixel    = {8'hFF, cr[7:0], cg[7:0], cb[7:0]};
        r.outcome      = OUTC_BLEND;
      end
      return r;
    endfunction

    function void note_plot(plot_t p);
      expected_writes.push_back(blend_pixel(p));
    endfunction

    function int outstanding();
      return expected_writes.size();
    endfunction

    function void check_write(pix_write_t got);
      pix_write_t want;
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: pixel write with no plot outstanding", $time);
        return;
      end
      want = expected_writes.pop_front();
      if (got.write_enable !== want.write_enable || got.word_address !== want.word_address ||
          got.buffer_index !== want.buffer_index || got.new_pixel !== want.new_pixel ||
          got.outcome !== want.outcome) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: pixel write mismatch", $time);
          $display("  expected we=%b addr=%h buf=%b pix=%h outcome=%0d", want.write_enable,
                   want.word_address, want.buffer_index, want.new_pixel, want.outcome);
          $display("  actual   we=%b addr=%h buf=%b pix=%h outcome=%0d", got.write_enable,
                   got.word_address, got.buffer_index, got.new_pixel, got.outcome);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  bit                no_idle = 1'b0;
  int                idle_cycles = 0;
  blend_scoreboard   sb;

  pab_in_if  in_pix ();
  pab_out_if out_pix ();

  pixel_alpha_blend_writer_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic plot_t make_plot(int unsigned x, int unsigned y, logic [PIX_W-1:0] col,
                                      logic gray, int unsigned pct, logic [PIX_W-1:0] old);
    plot_t p;
    p.pos_x       = x[COORD_W-1:0];
    p.pos_y       = y[COORD_W-1:0];
    p.src_color   = col;
    p.gray_enable = gray;
    p.opacity_pct = pct[PCT_W-1:0];
    p.old_pixel   = old;
    return p;
  endfunction

  function automatic plot_t rand_plot();
    plot_t       p;
    int unsigned w, h, r;
    logic [31:0] rx, ry;
    w  = 32'(sb.cfg.width);
    h  = 32'(sb.cfg.height);
    rx = $urandom;
    ry = $urandom;
    r  = $urandom_range(0, 99);
    if (r < 70 && w > 0 && h > 0) begin
      p.pos_x = COORD_W'($urandom_range(0, w - 1));
      p.pos_y = COORD_W'($urandom_range(0, h - 1));
    end else if (r < 82) begin
      p.pos_x = $urandom_range(0, 1) ? COORD_W'(w) : rx[COORD_W-1:0];
      p.pos_y = $urandom_range(0, 1) ? COORD_W'(h) : ry[COORD_W-1:0];
    end else begin
      p.pos_x = rx[COORD_W-1:0];
      p.pos_y = ry[COORD_W-1:0];
    end
    p.src_color = $urandom;
    r = $urandom_range(0, 99);
    if (r < 20) p.src_color[31:24] = 8'hFF;
    else if (r < 30) p.src_color[31:24] = 8'h00;
    r = $urandom_range(0, 99);
    if (r < 40) p.opacity_pct = PCT_W'(PCT_FULL);
    else if (r < 50) p.opacity_pct = PCT_W'($urandom_range(PCT_FULL + 1, 127));
    else if (r < 60) p.opacity_pct = '0;
    else p.opacity_pct = PCT_W'($urandom_range(0, 127));
    p.gray_enable = 1'($urandom_range(0, 1));
    p.old_pixel   = $urandom;
    return p;
  endfunction

  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                            input logic land, input logic mir, input logic dbuf);
    logic [CFG_DW-1:0] junk;
    junk = $urandom;
    cfg_write(REG_WIDTH, {junk[CFG_DW-1:COORD_W], w});
    junk = $urandom;
    cfg_write(REG_HEIGHT, {junk[CFG_DW-1:COORD_W], h});
    junk = $urandom;
    cfg_write(REG_LANDSCAPE, {junk[CFG_DW-1:1], land});
    junk = $urandom;
    cfg_write(REG_MIRROR, {junk[CFG_DW-1:1], mir});
    junk = $urandom;
    cfg_write(REG_DRAWBUF, {junk[CFG_DW-1:1], dbuf});
  endtask

  task automatic send_plot(input plot_t p, input bit hold);
    int gap;
    gap = pick_gap();
    if (hold) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
      while (sb.outstanding() != 0) @(posedge clk);
    end else if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid       <= 1'b1;
    in_pix.pos_x       <= p.pos_x;
    in_pix.pos_y       <= p.pos_y;
    in_pix.src_color   <= p.src_color;
    in_pix.gray_enable <= p.gray_enable;
    in_pix.opacity_pct <= p.opacity_pct;
    in_pix.old_pixel   <= p.old_pixel;
    do @(posedge clk); while (!in_pix.ready);
  endtask

  task automatic wait_quiet();
    in_pix.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                           input logic land, input logic mir, input logic dbuf,
                           input int n, input bit steady);
    set_screen(w, h, land, mir, dbuf);
    no_idle = steady;
    for (int i = 0; i < n; i++)
      send_plot(rand_plot(), i == n / 2 || $urandom_range(0, 99) == 0);
    wait_quiet();
  endtask

  // Note accepted plots, check accepted writes.
  always @(posedge clk) begin
    plot_t      p;
    pix_write_t w;
    if (rst_n && in_pix.valid && in_pix.ready) begin
      p.pos_x       = in_pix.pos_x;
      p.pos_y       = in_pix.pos_y;
      p.src_color   = in_pix.src_color;
      p.gray_enable = in_pix.gray_enable;
      p.opacity_pct = in_pix.opacity_pct;
      p.old_pixel   = in_pix.old_pixel;
      sb.note_plot(p);
    end
    if (rst_n && out_pix.valid && out_pix.ready) begin
      w.write_enable = out_pix.write_enable;
      w.word_address = out_pix.word_address;
      w.buffer_index = out_pix.buffer_index;
      w.new_pixel    = out_pix.new_pixel;
      w.outcome      = outcome_t'(out_pix.outcome);
      sb.check_write(w);
    end
  end

  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side back-pressure.
  initial begin
    int run_len;
    int gap;
    out_pix.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_pix.ready <= 1'b1;
      run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_pix.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    sb = new();
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_pix.valid       <= 1'b0;
    in_pix.pos_x       <= '0;
    in_pix.pos_y       <= '0;
    in_pix.src_color   <= '0;
    in_pix.gray_enable <= 1'b0;
    in_pix.opacity_pct <= '0;
    in_pix.old_pixel   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset screen: 240 x 320 portrait, no mirroring, buffer 0.
    send_plot(make_plot(0, 0, 32'hFF112233, 1'b0, 100, 32'h00000000), 1'b0);
    send_plot(make_plot(239, 319, 32'hFFFFFFFF, 1'b0, 100, 32'h12345678), 1'b0);
    send_plot(make_plot(240, 0, 32'hFF00FF00, 1'b0, 100, 32'h0), 1'b0);
    send_plot(make_plot(0, 320, 32'hFF00FF00, 1'b0, 100, 32'h0), 1'b0);
    send_plot(make_plot(1023, 1023, 32'hFFFFFFFF, 1'b1, 127, 32'hFFFFFFFF), 1'b0);
    send_plot(make_plot(10, 10, 32'h00ABCDEF, 1'b0, 100, 32'hFFFFFFFF), 1'b0);
    send_plot(make_plot(11, 10, 32'hFFABCDEF, 1'b0, 0, 32'hFFFFFFFF), 1'b0);
    send_plot(make_plot(12, 10, 32'hFF13579B, 1'b0, 127, 32'h0), 1'b0);
    send_plot(make_plot(13, 10, 32'hFF2468AC, 1'b0, 101, 32'h0), 1'b0);
    send_plot(make_plot(14, 10, 32'h80FF0000, 1'b0, 100, 32'h0000FF00), 1'b0);
    send_plot(make_plot(15, 10, 32'hFF00FF00, 1'b0, 50, 32'hFFFFFFFF), 1'b0);
    send_plot(make_plot(16, 10, 32'h01FFFFFF, 1'b0, 99, 32'h00000000), 1'b0);
    send_plot(make_plot(17, 10, 32'hFF808080, 1'b0, 99, 32'h7F7F7F7F), 1'b0);
    send_plot(make_plot(18, 10, 32'hFEFFFFFF, 1'b0, 100, 32'h00000000), 1'b0);
    send_plot(make_plot(19, 10, 32'h01123456, 1'b0, 100, 32'hFFFFFFFF), 1'b0);
    send_plot(make_plot(20, 10, 32'hFF102030, 1'b1, 100, 32'h0), 1'b0);
    send_plot(make_plot(21, 10, 32'h80FFFFFE, 1'b1, 60, 32'hA5A5A5A5), 1'b0);
    send_plot(make_plot(22, 10, 32'hFF00FF00, 1'b1, 127, 32'h0), 1'b0);
    send_plot(make_plot(0, 319, 32'h00000000, 1'b0, 0, 32'hFFFFFFFF), 1'b0);
    send_plot(make_plot(239, 0, 32'hFFABCDEF, 1'b0, 100, 32'h55555555), 1'b0);
    wait_quiet();

    run_phase(10'd240, 10'd320, 1'b0, 1'b0, 1'b0, 90, 1'b0);
    run_phase(10'd1023, 10'd1023, 1'b1, 1'b1, 1'b1, 90, 1'b0);
    run_phase(10'd1, 10'd1, 1'b0, 1'b1, 1'b0, 60, 1'b0);
    run_phase(10'd1, 10'd1023, 1'b1, 1'b0, 1'b1, 80, 1'b0);
    run_phase(10'd1023, 10'd1, 1'b0, 1'b0, 1'b1, 80, 1'b1);
    run_phase(COORD_W'($urandom_range(2, 1022)), COORD_W'($urandom_range(2, 1022)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              90, 1'b0);
    run_phase(10'd0, 10'd5, 1'b0, 1'b1, 1'b1, 20, 1'b0);
    run_phase(10'd240, 10'd320, 1'b1, 1'b1, 1'b0, 90, 1'b0);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
